// ===== sv/ckb_pkg.sv =====
// shared types, widths and constants of the color keyed sprite blitter
package ckb_pkg;

    // screen geometry
    localparam int SCREEN_COLUMNS = 320;
    localparam int SCREEN_BYTES   = 64000;

    // field widths
    localparam int X_W          = 9;
    localparam int Y_W          = 8;
    localparam int FRAME_W      = 10;
    localparam int COLOR_W      = 8;
    localparam int ADDR_W       = 17;
    localparam int FULL_ADDR_W  = 18;
    localparam int AREA_W       = X_W + Y_W;
    localparam int BASE_W       = 16;
    localparam int CFG_DATA_W   = 10;
    localparam int CFG_INDEX_W  = 3;
    localparam int TDATA_W      = 48;
    localparam int TUSER_W      = 2;

    // zero fill above the result fields in tdata
    localparam int TDATA_PAD_W  = TDATA_W - 2 * ADDR_W - COLOR_W;
    // frame number times sprite area
    localparam int FRAME_PROD_W = FRAME_W + AREA_W;

    // sprite size after reset
    localparam int SPRITE_SIZE_RESET = 16;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEST_X            = 3'd0,
        REG_DEST_Y            = 3'd1,
        REG_SPRITE_WIDTH      = 3'd2,
        REG_SPRITE_HEIGHT     = 3'd3,
        REG_FRAME_INDEX       = 3'd4,
        REG_MIRROR            = 3'd5,
        REG_OVERRIDE_COLOR    = 3'd6,
        REG_TRANSPARENT_COLOR = 3'd7
    } reg_index_t;

    // configuration as seen by the datapath; width and height never zero
    typedef struct packed {
        logic [X_W-1:0]     dest_x;
        logic [Y_W-1:0]     dest_y;
        logic [X_W-1:0]     width;
        logic [Y_W-1:0]     height;
        logic [FRAME_W-1:0] frame_index;
        logic               mirror;
        logic [COLOR_W-1:0] override_color;
        logic [COLOR_W-1:0] transparent_color;
    } cfg_t;

    // one captured pixel with its sprite position
    typedef struct packed {
        logic [COLOR_W-1:0] pixel;
        logic [Y_W-1:0]     row;
        logic [X_W-1:0]     col;
        logic [X_W-1:0]     dcol;
        logic [AREA_W-1:0]  row_offset;
        logic               last;
    } pos_t;

endpackage

// ===== sv/ckb_cfg.sv =====
// configuration registers and the registered sprite area
module ckb_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ckb_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ckb_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ckb_pkg::cfg_t                     cfg,
    output logic [ckb_pkg::AREA_W-1:0]        area
);

    logic [ckb_pkg::X_W-1:0]     dest_x_reg;
    logic [ckb_pkg::Y_W-1:0]     dest_y_reg;
    logic [ckb_pkg::X_W-1:0]     width_reg;
    logic [ckb_pkg::Y_W-1:0]     height_reg;
    logic [ckb_pkg::FRAME_W-1:0] frame_index_reg;
    logic                        mirror_reg;
    logic [ckb_pkg::COLOR_W-1:0] override_color_reg;
    logic [ckb_pkg::COLOR_W-1:0] transparent_color_reg;
    logic [ckb_pkg::AREA_W-1:0]  area_reg;
    logic [ckb_pkg::X_W-1:0]     width_eff;
    logic [ckb_pkg::Y_W-1:0]     height_eff;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg            <= '0;
            dest_y_reg            <= '0;
            width_reg             <= ckb_pkg::X_W'(ckb_pkg::SPRITE_SIZE_RESET);
            height_reg            <= ckb_pkg::Y_W'(ckb_pkg::SPRITE_SIZE_RESET);
            frame_index_reg       <= '0;
            mirror_reg            <= 1'b0;
            override_color_reg    <= '0;
            transparent_color_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (ckb_pkg::reg_index_t'(cfg_index))
                ckb_pkg::REG_DEST_X:            dest_x_reg <= cfg_data[ckb_pkg::X_W-1:0];
                ckb_pkg::REG_DEST_Y:            dest_y_reg <= cfg_data[ckb_pkg::Y_W-1:0];
                ckb_pkg::REG_SPRITE_WIDTH:      width_reg <= cfg_data[ckb_pkg::X_W-1:0];
                ckb_pkg::REG_SPRITE_HEIGHT:     height_reg <= cfg_data[ckb_pkg::Y_W-1:0];
                ckb_pkg::REG_FRAME_INDEX:       frame_index_reg <= cfg_data;
                ckb_pkg::REG_MIRROR:            mirror_reg <= cfg_data[0];
                ckb_pkg::REG_OVERRIDE_COLOR:    override_color_reg <= cfg_data[ckb_pkg::COLOR_W-1:0];
                ckb_pkg::REG_TRANSPARENT_COLOR: transparent_color_reg <= cfg_data[ckb_pkg::COLOR_W-1:0];
                default:                        mirror_reg <= mirror_reg;
            endcase
        end
    end

    // a size of zero acts as one
    assign width_eff  = (width_reg == '0) ? ckb_pkg::X_W'(1) : width_reg;
    assign height_eff = (height_reg == '0) ? ckb_pkg::Y_W'(1) : height_reg;

    // sprite area, registered from the size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_reg <= ckb_pkg::AREA_W'(ckb_pkg::SPRITE_SIZE_RESET * ckb_pkg::SPRITE_SIZE_RESET);
        end
        else
        begin
            area_reg <= ckb_pkg::AREA_W'(width_eff) * ckb_pkg::AREA_W'(height_eff);
        end
    end

    assign cfg.dest_x            = dest_x_reg;
    assign cfg.dest_y            = dest_y_reg;
    assign cfg.width             = width_eff;
    assign cfg.height            = height_eff;
    assign cfg.frame_index       = frame_index_reg;
    assign cfg.mirror            = mirror_reg;
    assign cfg.override_color    = override_color_reg;
    assign cfg.transparent_color = transparent_color_reg;
    assign area                  = area_reg;

endmodule

// ===== sv/ckb_pos.sv =====
// row and column counters and the input register
module ckb_pos (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ckb_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    input  logic [ckb_pkg::COLOR_W-1:0]   in_pixel,
    input  logic                          take,
    output logic                          in_ready,
    output logic                          st_valid,
    output ckb_pkg::pos_t                 st
);

    logic [ckb_pkg::Y_W-1:0]   row_reg;
    logic [ckb_pkg::X_W-1:0]   col_reg;
    logic                      st_valid_reg;
    ckb_pkg::pos_t             st_reg;
    logic                      accept;
    logic [ckb_pkg::X_W:0]     col_inc;
    logic [ckb_pkg::Y_W:0]     row_inc;
    logic                      row_end;
    logic                      sprite_end;
    logic [ckb_pkg::X_W-1:0]   dcol;
    logic [ckb_pkg::AREA_W-1:0] row_offset;

    assign in_ready = !st_valid_reg || take;
    assign accept   = in_valid && in_ready;

    // end of row and end of sprite
    assign col_inc    = {1'b0, col_reg} + (ckb_pkg::X_W+1)'(1);
    assign row_inc    = {1'b0, row_reg} + (ckb_pkg::Y_W+1)'(1);
    assign row_end    = col_inc >= {1'b0, cfg.width};
    assign sprite_end = row_end && (row_inc >= {1'b0, cfg.height});

    // destination column, reversed when mirrored
    always_comb
    begin
        if (!cfg.mirror)
        begin
            dcol = col_reg;
        end
        else if (col_reg < cfg.width)
        begin
            dcol = cfg.width - ckb_pkg::X_W'(1) - col_reg;
        end
        else
        begin
            dcol = '0;
        end
    end

    assign row_offset = ckb_pkg::AREA_W'(row_reg) * ckb_pkg::AREA_W'(cfg.width);

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            priority if (sprite_end)
            begin
                row_reg <= '0;
                col_reg <= '0;
            end
            else if (row_end)
            begin
                row_reg <= row_inc[ckb_pkg::Y_W-1:0];
                col_reg <= '0;
            end
            else
            begin
                col_reg <= col_inc[ckb_pkg::X_W-1:0];
            end
        end
    end

    // input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            st_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            st_valid_reg <= 1'b0;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            st_reg.pixel      <= in_pixel;
            st_reg.row        <= row_reg;
            st_reg.col        <= col_reg;
            st_reg.dcol       <= dcol;
            st_reg.row_offset <= row_offset;
            st_reg.last       <= sprite_end;
        end
    end

    assign st_valid = st_valid_reg;
    assign st       = st_reg;

`ifndef SYNTH
    // the last pixel of a sprite returns both counters to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sprite_end) |=> (row_reg == '0 && col_reg == '0))
        else $error("counters not cleared after last pixel");

    // inside a row the column steps by one and the row holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !row_end) |=>
        (col_reg == $past(col_reg) + ckb_pkg::X_W'(1) && row_reg == $past(row_reg)))
        else $error("column did not advance inside a row");

    // a captured word carries the position the counters held
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (st_reg.col == $past(col_reg) && st_reg.row == $past(row_reg)))
        else $error("captured position does not match counters");
`endif

endmodule

// ===== sv/ckb_out.sv =====
// address, source offset and color logic with the result register
module ckb_out (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ckb_pkg::cfg_t                     cfg,
    input  logic [ckb_pkg::AREA_W-1:0]        area,
    input  logic                              st_valid,
    input  ckb_pkg::pos_t                     st,
    input  logic                              out_ready,
    output logic                              take,
    output logic                              out_valid,
    output logic [ckb_pkg::TDATA_W-1:0]       out_data,
    output logic                              out_last,
    output logic [ckb_pkg::TUSER_W-1:0]       out_user
);

    logic                               valid_reg;
    logic [ckb_pkg::ADDR_W-1:0]         address_reg;
    logic [ckb_pkg::COLOR_W-1:0]        color_reg;
    logic [ckb_pkg::ADDR_W-1:0]         source_reg;
    logic                               we_reg;
    logic                               oob_reg;
    logic                               last_reg;
    logic [ckb_pkg::Y_W:0]              y_sum;
    logic [ckb_pkg::FULL_ADDR_W-1:0]    addr_full;
    logic                               oob;
    logic [ckb_pkg::FRAME_PROD_W-1:0]   frame_prod;
    logic [ckb_pkg::FULL_ADDR_W-1:0]    src_full;
    logic [ckb_pkg::COLOR_W-1:0]        color;
    logic                               opaque;

    assign take = st_valid && (!valid_reg || out_ready);

    // destination address on the full width, then the bounds check
    assign y_sum     = {1'b0, cfg.dest_y} + {1'b0, st.row};
    assign addr_full = ckb_pkg::FULL_ADDR_W'(y_sum)
                     * ckb_pkg::FULL_ADDR_W'(ckb_pkg::SCREEN_COLUMNS)
                     + ckb_pkg::FULL_ADDR_W'(cfg.dest_x)
                     + ckb_pkg::FULL_ADDR_W'(st.dcol);
    assign oob       = addr_full >= ckb_pkg::FULL_ADDR_W'(ckb_pkg::SCREEN_BYTES);

    // source offset, frame base wraps at 16 bits
    assign frame_prod = ckb_pkg::FRAME_PROD_W'(cfg.frame_index)
                      * ckb_pkg::FRAME_PROD_W'(area);
    assign src_full   = ckb_pkg::FULL_ADDR_W'(frame_prod[ckb_pkg::BASE_W-1:0])
                      + ckb_pkg::FULL_ADDR_W'(st.row_offset)
                      + ckb_pkg::FULL_ADDR_W'(st.col);

    // color key and override
    assign color  = (cfg.override_color > cfg.transparent_color) ? cfg.override_color : st.pixel;
    assign opaque = st.pixel != cfg.transparent_color;

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            address_reg <= addr_full[ckb_pkg::ADDR_W-1:0];
            color_reg   <= color;
            source_reg  <= src_full[ckb_pkg::ADDR_W-1:0];
            we_reg      <= opaque && !oob;
            oob_reg     <= oob;
            last_reg    <= st.last;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = {{ckb_pkg::TDATA_PAD_W{1'b0}}, source_reg, color_reg, address_reg};
    assign out_last  = last_reg;
    assign out_user  = {oob_reg, we_reg};

`ifndef SYNTH
    // a write is never issued outside screen memory
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> !(we_reg && oob_reg))
        else $error("write enabled on out of bounds address");
`endif

endmodule

// ===== sv/color_keyed_sprite_blitter.sv =====
// top level of the color keyed sprite blitter
//
//  port group       dir  word contents
//  s_axis_*         in   tdata[7:0] pixel_value
//  m_axis_*         out  tdata: write_address, write_color, source_offset;
//                        tuser: write_enable, out_of_bounds; tlast: last_pixel
//  cfg_*            in   register write, index 0..7, 10 bit data
//
//  one pixel word per cycle sustained while m_axis_tready is high; a result
//  word passes the input register, then the result register, to reach m_axis
//  the counters step on each accepted pixel word; the address and offset
//  adders are combinational
//  reset clears counters, pipeline valids and config registers (size 16x16)
//  a stall on the master side holds the result register and backs up into
//  the input register; both stages keep moving as long as tready is high
module color_keyed_sprite_blitter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ckb_pkg::COLOR_W-1:0]         s_axis_tdata,  // [7:0] pixel_value
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [16:0] write_address, [24:17] write_color, [41:25] source_offset, [47:42] zero
    output logic [ckb_pkg::TDATA_W-1:0]         m_axis_tdata,
    output logic                                m_axis_tlast,
    output logic [ckb_pkg::TUSER_W-1:0]         m_axis_tuser,  // [0] write_enable, [1] out_of_bounds
    input  logic                                cfg_we,
    input  logic [ckb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ckb_pkg::CFG_DATA_W-1:0]      cfg_data
);

    ckb_pkg::cfg_t                    cfg;
    logic [ckb_pkg::AREA_W-1:0]       area;
    logic                             take;
    logic                             st_valid;
    ckb_pkg::pos_t                    st;

    // configuration registers
    ckb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .area      (area)
    );

    // position counters and input register
    ckb_pos u_pos (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (s_axis_tvalid),
        .in_pixel (s_axis_tdata),
        .take     (take),
        .in_ready (s_axis_tready),
        .st_valid (st_valid),
        .st       (st)
    );

    // result computation and output register
    ckb_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .area      (area),
        .st_valid  (st_valid),
        .st        (st),
        .out_ready (m_axis_tready),
        .take      (take),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast),
        .out_user  (m_axis_tuser)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// testbench for the color keyed sprite blitter: directed and random pixel streams
`timescale 1ns / 100ps

module testbench;

    // register copy kept by the predictor, held at register widths
    typedef struct {
        logic [8:0] dest_x;
        logic [7:0] dest_y;
        logic [8:0] width;
        logic [7:0] height;
        logic [9:0] frame_index;
        logic       mirror;
        logic [7:0] override_color;
        logic [7:0] transparent_color;
    } blit_regs_t;

    // one frame buffer write as the block should report it
    typedef struct {
        logic [16:0] address;
        logic [7:0]  color;
        logic        enable;
        logic [16:0] offset;
        logic        oob;
        logic        last;
    } blit_write_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [1:0]  m_axis_tuser;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = 3'd0;
    logic [9:0]  cfg_data = 10'd0;

    // predictor state
    blit_regs_t  regs;
    logic [7:0]  row_cnt;
    logic [8:0]  col_cnt;
    blit_write_t pending_writes[$];

    // idling control and run statistics
    bit          gaps_on;
    bit          stalls_on;
    int unsigned stall_left = 0;
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned pixels_sent = 0;
    int unsigned settings_used = 0;
    int unsigned transparent_seen = 0;
    int unsigned oob_seen = 0;
    int unsigned sprite_ends = 0;
    int unsigned wraps_seen = 0;

    color_keyed_sprite_blitter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] pixel_value
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [16:0] address, [24:17] color, [41:25] offset
        .m_axis_tlast  (m_axis_tlast),   // last_pixel
        .m_axis_tuser  (m_axis_tuser),   // [0] write_enable, [1] out_of_bounds
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("testbench failed");
        $finish;
    end

    // frame buffer write for one source pixel; advances the row and column counters
    function automatic blit_write_t blit_pixel(input logic [7:0] pix);
        blit_write_t r;
        int unsigned w, h, col, row, dcol, full, base, src;
        logic        row_end, sprite_end;
        w = (regs.width == 0) ? 1 : 32'(regs.width);
        h = (regs.height == 0) ? 1 : 32'(regs.height);
        col = 32'(col_cnt);
        row = 32'(row_cnt);
        // mirrored column; a column past the end lands on column zero
        if (regs.mirror)
            dcol = (col < w) ? (w - 1 - col) : 0;
        else
            dcol = col;
        full = (32'(regs.dest_y) + row) * ckb_pkg::SCREEN_COLUMNS
             + 32'(regs.dest_x) + dcol;
        base = (32'(regs.frame_index) * w * h) & 32'hFFFF;
        src = base + row * w + col;
        r.address = full[16:0];
        r.color = (regs.override_color > regs.transparent_color) ? regs.override_color : pix;
        r.oob = (full >= ckb_pkg::SCREEN_BYTES);
        r.enable = (pix != regs.transparent_color) && !r.oob;
        r.offset = src[16:0];
        row_end = (col + 1) >= w;
        sprite_end = row_end && ((row + 1) >= h);
        r.last = sprite_end;
        // counter update
        if (sprite_end)
        begin
            row_cnt = 8'd0;
            col_cnt = 9'd0;
        end
        else if (row_end)
        begin
            col_cnt = 9'd0;
            row_cnt = row_cnt + 8'd1;
        end
        else
            col_cnt = col_cnt + 9'd1;
        // statistics
        if (pix == regs.transparent_color)
            transparent_seen++;
        if (r.oob)
            oob_seen++;
        if (sprite_end)
            sprite_ends++;
        if (full > 32'h1FFFF)
            wraps_seen++;
        return r;
    endfunction

    // pixels left until the counters close the current sprite, capped
    function automatic int unsigned pixels_to_sprite_end();
        int unsigned w, h, r, c, n;
        logic        row_end;
        w = (regs.width == 0) ? 1 : 32'(regs.width);
        h = (regs.height == 0) ? 1 : 32'(regs.height);
        r = 32'(row_cnt);
        c = 32'(col_cnt);
        n = 0;
        while (n < 64)
        begin
            n++;
            row_end = (c + 1) >= w;
            if (row_end && (r + 1) >= h)
                break;
            if (row_end)
            begin
                c = 0;
                r = (r + 1) & 8'hFF;
            end
            else
                c++;
        end
        return n;
    endfunction

    // mismatch reporting
    task automatic report_mismatch(input string what, input logic [47:0] got,
                                   input logic [47:0] want);
        mismatches++;
        $display("mismatch at result %0d: %s got 0x%0h, predicted 0x%0h",
                 results_checked, what, got, want);
    endtask

    task automatic check_field(input string what, input logic [47:0] got,
                               input logic [47:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // sink side: random stall bursts on m_axis_tready
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // predict on each accepted pixel word, check each accepted result word
    always @(posedge clk)
    begin
        blit_write_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                pending_writes.push_back(blit_pixel(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_writes.size() == 0)
                    report_mismatch("result word with no pixel pending", m_axis_tdata, 48'd0);
                else
                begin
                    want = pending_writes.pop_front();
                    check_field("write_address", 48'(m_axis_tdata[16:0]), 48'(want.address));
                    check_field("write_color", 48'(m_axis_tdata[24:17]), 48'(want.color));
                    check_field("source_offset", 48'(m_axis_tdata[41:25]), 48'(want.offset));
                    check_field("tdata padding", 48'(m_axis_tdata[47:42]), 48'd0);
                    check_field("write_enable", 48'(m_axis_tuser[0]), 48'(want.enable));
                    check_field("out_of_bounds", 48'(m_axis_tuser[1]), 48'(want.oob));
                    check_field("last_pixel", 48'(m_axis_tlast), 48'(want.last));
                end
                results_checked++;
            end
        end
    end

    // register write; keeps cfg_we high so writes can run back to back
    task automatic write_reg(input ckb_pkg::reg_index_t idx, input int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[9:0];
        @(posedge clk);
        case (idx)
            ckb_pkg::REG_DEST_X:            regs.dest_x = val[8:0];
            ckb_pkg::REG_DEST_Y:            regs.dest_y = val[7:0];
            ckb_pkg::REG_SPRITE_WIDTH:      regs.width = val[8:0];
            ckb_pkg::REG_SPRITE_HEIGHT:     regs.height = val[7:0];
            ckb_pkg::REG_FRAME_INDEX:       regs.frame_index = val[9:0];
            ckb_pkg::REG_MIRROR:            regs.mirror = val[0];
            ckb_pkg::REG_OVERRIDE_COLOR:    regs.override_color = val[7:0];
            ckb_pkg::REG_TRANSPARENT_COLOR: regs.transparent_color = val[7:0];
            default: ;
        endcase
    endtask

    task automatic end_reg_writes();
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // one pixel word, with an occasional gap in front
    task automatic send_pixel(input logic [7:0] pix);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pix;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // hold the source until every predicted write has come out
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_writes.size() != 0);
    endtask

    // pixel value, often equal to the transparent index
    function automatic logic [7:0] pick_pixel();
        if ($urandom_range(0, 3) == 0)
            return regs.transparent_color;
        return 8'($urandom_range(0, 255));
    endfunction

    // random register setting, mostly small sprites, sometimes extremes
    task automatic randomize_regs();
        int unsigned ovr;
        case ($urandom_range(0, 7))
            0: write_reg(ckb_pkg::REG_DEST_X, 0);
            1: write_reg(ckb_pkg::REG_DEST_X, 511);
            2: write_reg(ckb_pkg::REG_DEST_X, $urandom_range(0, 1023));
            default: write_reg(ckb_pkg::REG_DEST_X, $urandom_range(0, 319));
        endcase
        case ($urandom_range(0, 7))
            0: write_reg(ckb_pkg::REG_DEST_Y, 0);
            1: write_reg(ckb_pkg::REG_DEST_Y, 255);
            2: write_reg(ckb_pkg::REG_DEST_Y, $urandom_range(0, 1023));
            default: write_reg(ckb_pkg::REG_DEST_Y, $urandom_range(0, 199));
        endcase
        case ($urandom_range(0, 11))
            0: write_reg(ckb_pkg::REG_SPRITE_WIDTH, 0);
            1: write_reg(ckb_pkg::REG_SPRITE_WIDTH, $urandom_range(0, 1) ? 320 : 511);
            default: write_reg(ckb_pkg::REG_SPRITE_WIDTH, $urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 11))
            0: write_reg(ckb_pkg::REG_SPRITE_HEIGHT, 0);
            1: write_reg(ckb_pkg::REG_SPRITE_HEIGHT, $urandom_range(0, 1) ? 200 : 255);
            default: write_reg(ckb_pkg::REG_SPRITE_HEIGHT, $urandom_range(1, 8));
        endcase
        write_reg(ckb_pkg::REG_FRAME_INDEX, $urandom_range(0, 1023));
        write_reg(ckb_pkg::REG_MIRROR, $urandom_range(0, 1023));
        ovr = $urandom_range(0, 255);
        write_reg(ckb_pkg::REG_OVERRIDE_COLOR, ovr);
        write_reg(ckb_pkg::REG_TRANSPARENT_COLOR,
                  ($urandom_range(0, 3) == 0) ? ovr : $urandom_range(0, 255));
        end_reg_writes();
    endtask

    // sprites with random content under random settings, mostly run to their end
    task automatic run_sprite_phases(input int unsigned target, input bit idle);
        int unsigned start, n;
        start = pixels_sent;
        while (pixels_sent - start < target)
        begin
            wait_drained();
            randomize_regs();
            gaps_on = idle && ($urandom_range(0, 3) != 0);
            stalls_on = idle && ($urandom_range(0, 3) != 0);
            n = pixels_to_sprite_end();
            if ($urandom_range(0, 4) == 0)
                n = $urandom_range(1, n);
            repeat (n) send_pixel(pick_pixel());
        end
    endtask

    // reset settings: 16x16 sprite, transparent index 0, no override
    task automatic test_reset_defaults();
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h55);
    endtask

    // width and height cut below the counters while a sprite is open
    task automatic test_size_shrink();
        wait_drained();
        write_reg(ckb_pkg::REG_SPRITE_WIDTH, 2);
        write_reg(ckb_pkg::REG_MIRROR, 1);
        end_reg_writes();
        send_pixel(8'hAA);
        wait_drained();
        write_reg(ckb_pkg::REG_SPRITE_HEIGHT, 1);
        end_reg_writes();
        send_pixel(8'h01);
        send_pixel(8'h80);
    endtask

    // zero sizes act as one; largest frame number
    task automatic test_zero_size();
        wait_drained();
        write_reg(ckb_pkg::REG_SPRITE_WIDTH, 0);
        write_reg(ckb_pkg::REG_SPRITE_HEIGHT, 0);
        write_reg(ckb_pkg::REG_FRAME_INDEX, 1023);
        end_reg_writes();
        send_pixel(8'h01);
        send_pixel(8'hFE);
        send_pixel(8'h00);
    endtask

    // override above, equal to and below the transparent index
    task automatic test_color_key();
        wait_drained();
        write_reg(ckb_pkg::REG_MIRROR, 0);
        write_reg(ckb_pkg::REG_DEST_X, 10);
        write_reg(ckb_pkg::REG_DEST_Y, 20);
        write_reg(ckb_pkg::REG_SPRITE_WIDTH, 4);
        write_reg(ckb_pkg::REG_SPRITE_HEIGHT, 2);
        write_reg(ckb_pkg::REG_FRAME_INDEX, 5);
        write_reg(ckb_pkg::REG_TRANSPARENT_COLOR, 8'h80);
        write_reg(ckb_pkg::REG_OVERRIDE_COLOR, 8'h81);
        end_reg_writes();
        send_pixel(8'h80);
        send_pixel(8'h7F);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        wait_drained();
        write_reg(ckb_pkg::REG_OVERRIDE_COLOR, 8'h80);
        end_reg_writes();
        send_pixel(8'h80);
        send_pixel(8'hFF);
        wait_drained();
        write_reg(ckb_pkg::REG_TRANSPARENT_COLOR, 8'hFF);
        end_reg_writes();
        send_pixel(8'hFF);
        send_pixel(8'h01);
    endtask

    // bottom right corner: last byte inside the screen and the first one past it
    task automatic test_screen_edge();
        wait_drained();
        write_reg(ckb_pkg::REG_DEST_X, 319);
        write_reg(ckb_pkg::REG_DEST_Y, 199);
        write_reg(ckb_pkg::REG_SPRITE_WIDTH, 2);
        write_reg(ckb_pkg::REG_SPRITE_HEIGHT, 2);
        write_reg(ckb_pkg::REG_OVERRIDE_COLOR, 0);
        write_reg(ckb_pkg::REG_TRANSPARENT_COLOR, 0);
        end_reg_writes();
        send_pixel(8'h11);
        send_pixel(8'h22);
        send_pixel(8'h33);
        send_pixel(8'h00);
    endtask

    // one pixel wide column from the largest origin, walking past the 17 bit address range
    task automatic test_address_wrap();
        wait_drained();
        write_reg(ckb_pkg::REG_DEST_X, 511);
        write_reg(ckb_pkg::REG_DEST_Y, 255);
        write_reg(ckb_pkg::REG_SPRITE_WIDTH, 1);
        write_reg(ckb_pkg::REG_SPRITE_HEIGHT, 255);
        write_reg(ckb_pkg::REG_MIRROR, 1);
        end_reg_writes();
        repeat (180) send_pixel(pick_pixel());
    endtask

    task automatic test_random_sprites();
        run_sprite_phases(300, 1'b1);
    endtask

    // back to back words with no idling on either side
    task automatic test_full_rate();
        run_sprite_phases(60, 1'b0);
    endtask

    // test sequence
    initial
    begin
        regs.dest_x = 9'd0;
        regs.dest_y = 8'd0;
        regs.width = 9'(ckb_pkg::SPRITE_SIZE_RESET);
        regs.height = 8'(ckb_pkg::SPRITE_SIZE_RESET);
        regs.frame_index = 10'd0;
        regs.mirror = 1'b0;
        regs.override_color = 8'd0;
        regs.transparent_color = 8'd0;
        row_cnt = 8'd0;
        col_cnt = 9'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_size_shrink();
        test_zero_size();
        test_color_key();
        test_screen_edge();
        test_address_wrap();
        test_random_sprites();
        test_full_rate();

        wait_drained();
        repeat (8) @(posedge clk);
        $display("%0d pixels under %0d register settings, %0d results checked",
                 pixels_sent, settings_used, results_checked);
        $display("%0d transparent, %0d off screen, %0d sprite ends, %0d address wraps",
                 transparent_seen, oob_seen, sprite_ends, wraps_seen);
        if (mismatches == 0 && pending_writes.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
